// ===== hdl/cts_pkg.sv =====
package cts_pkg;

	localparam int NumStates     = 16;
	localparam int SlotsPerState = 8;
	localparam int NumVars       = 16;

	localparam int StateW = $clog2(NumStates);
	localparam int VarW   = $clog2(NumVars);

	typedef enum logic [1:0] {
		OpLoad    = 2'd0,
		OpSetNum  = 2'd1,
		OpSetBool = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CmpEq = 3'd0,
		CmpNe = 3'd1,
		CmpLt = 3'd2,
		CmpGt = 3'd3,
		CmpGe = 3'd4,
		CmpLe = 3'd5
	} cmp_t;

	// one condition slot without its used bit, which lives in flops
	typedef struct packed {
		logic [3:0]         var_idx;
		logic               kind;
		logic [2:0]         code;
		logic signed [31:0] num_target;
		logic               bool_target;
		logic [3:0]         nxt;
	} rule_t;

	localparam int RuleW = $bits(rule_t);

	function automatic logic rule_fires(rule_t r, logic signed [31:0] nval, logic bval);
		logic f;
		f = 1'b0;
		if (!r.kind) begin
			case (r.code)
				CmpEq:   f = (nval == r.num_target);
				CmpNe:   f = (nval != r.num_target);
				CmpLt:   f = (nval < r.num_target);
				CmpGt:   f = (nval > r.num_target);
				CmpGe:   f = (nval >= r.num_target);
				CmpLe:   f = (nval <= r.num_target);
				default: f = 1'b0;
			endcase
		end else begin
			// ordering compares on booleans never fire
			case (r.code)
				CmpEq:   f = (bval == r.bool_target);
				CmpNe:   f = (bval != r.bool_target);
				default: f = 1'b0;
			endcase
		end
		return f;
	endfunction

endpackage

// ===== hdl/condition_table_state_machine.sv =====
// channel | direction | handshake             | payload
// cfg     | in        | cfg_valid / cfg_ready | cfg_data (start state)
// in      | in        | in_valid / in_ready   | op, row_state, row_slot, row_used, var_index,
//         |           |                       | var_kind, compare_code, fixed_value,
//         |           |                       | bool_value, next_state
// out     | out       | out_valid / out_ready | current_state, changed
//
// For each item, the accept cycle reads the current state's row from the
// slot banks and the numeric variable memory, the next cycle compares all slots in
// parallel and loads the result register. A new item is taken once no item is in flight
// and the result register is free or being drained in the same cycle.
// No clearing pass after reset: used bits and variable valid bits are flops.
// A stalled output holds the result and keeps in_ready low; cfg_ready is low while an
// item is offered or in flight.
module condition_table_state_machine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [3:0]         row_state,
	input  logic [2:0]         row_slot,
	input  logic               row_used,
	input  logic [3:0]         var_index,
	input  logic               var_kind,
	input  logic [2:0]         compare_code,
	input  logic signed [31:0] fixed_value,
	input  logic               bool_value,
	input  logic [3:0]         next_state,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         current_state,
	output logic               changed
);

	logic [cts_pkg::StateW-1:0] state_q;
	logic [cts_pkg::NumStates-1:0][cts_pkg::SlotsPerState-1:0] used_q;
	logic [cts_pkg::NumVars-1:0] bool_q;
	logic [cts_pkg::NumVars-1:0] nvalid_q;

	logic                busy_s1;
	logic                set_s1;
	logic                isnum_s1;
	logic [3:0]          var_s1;
	logic signed [31:0]  fval_s1;
	logic                bval_s1;
	logic                nvalid_s1;

	logic                       out_valid_q;
	logic [cts_pkg::StateW-1:0] cur_q;
	logic                       changed_q;

	logic                       in_fire;
	logic                       load_hit;
	logic                       set_ok;
	logic [cts_pkg::StateW-1:0] row_idx;
	logic [cts_pkg::VarW-1:0]   var_idx;
	cts_pkg::rule_t             wr_rule;
	cts_pkg::rule_t             bank_rd [cts_pkg::SlotsPerState];
	logic signed [31:0]         num_rd;
	logic signed [31:0]         num_val;
	logic [cts_pkg::StateW-1:0] nstate;
	logic                       fired;

	assign cfg_ready = !busy_s1 && !in_valid;
	assign in_ready  = !busy_s1 && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;

	assign row_idx = row_state[cts_pkg::StateW-1:0];
	assign var_idx = var_index[cts_pkg::VarW-1:0];

	assign load_hit = in_fire && (op == cts_pkg::OpLoad)
		&& (int'(row_state) < cts_pkg::NumStates)
		&& (int'(row_slot) < cts_pkg::SlotsPerState);
	assign set_ok = ((op == cts_pkg::OpSetNum) || (op == cts_pkg::OpSetBool))
		&& (int'(var_index) < cts_pkg::NumVars);

	always_comb begin
		wr_rule.var_idx     = var_index;
		wr_rule.kind        = var_kind;
		wr_rule.code        = compare_code;
		wr_rule.num_target  = fixed_value;
		wr_rule.bool_target = bool_value;
		wr_rule.nxt         = next_state;
	end

	// one bank per slot, all read at the current state
	for (genvar k = 0; k < cts_pkg::SlotsPerState; k++) begin : g_bank
		cts_ram #(
			.Width(cts_pkg::RuleW),
			.Depth(cts_pkg::NumStates)
		) u_bank (
			.clk   (clk),
			.we    (load_hit && (int'(row_slot) == k)),
			.waddr (row_idx),
			.wdata (wr_rule),
			.raddr (state_q),
			.rdata (bank_rd[k])
		);
	end

	cts_ram #(
		.Width(32),
		.Depth(cts_pkg::NumVars)
	) u_numvar (
		.clk   (clk),
		.we    (in_fire && set_ok && (op == cts_pkg::OpSetNum)),
		.waddr (var_idx),
		.wdata (fixed_value),
		.raddr (var_idx),
		.rdata (num_rd)
	);

	// a numeric set compares against its own new value, and so does a boolean set
	always_comb begin
		num_val = isnum_s1 ? fval_s1 : (nvalid_s1 ? num_rd : 32'sd0);
		nstate  = state_q;
		fired   = 1'b0;
		for (int k = 0; k < cts_pkg::SlotsPerState; k++) begin
			if (set_s1 && used_q[state_q][k] && (bank_rd[k].var_idx == var_s1)
				&& cts_pkg::rule_fires(bank_rd[k], num_val, bval_s1)) begin
				nstate = bank_rd[k].nxt[cts_pkg::StateW-1:0];
				fired  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			used_q      <= '0;
			bool_q      <= '0;
			nvalid_q    <= '0;
			busy_s1     <= 1'b0;
			set_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_s1 <= in_fire;
			if (in_fire) begin
				set_s1 <= set_ok;
			end
			if (load_hit) begin
				used_q[row_idx][row_slot] <= row_used;
			end
			if (in_fire && set_ok && (op == cts_pkg::OpSetBool)) begin
				bool_q[var_idx] <= bool_value;
			end
			if (in_fire && set_ok && (op == cts_pkg::OpSetNum)) begin
				nvalid_q[var_idx] <= 1'b1;
			end
			if (busy_s1) begin
				state_q     <= nstate;
				out_valid_q <= 1'b1;
			end else begin
				if (cfg_valid && cfg_ready) begin
					state_q <= cfg_data[cts_pkg::StateW-1:0];
				end
				if (out_valid_q && out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			isnum_s1  <= (op == cts_pkg::OpSetNum);
			var_s1    <= var_index;
			fval_s1   <= fixed_value;
			bval_s1   <= (op == cts_pkg::OpSetBool) ? bool_value : bool_q[var_idx];
			nvalid_s1 <= nvalid_q[var_idx];
		end
		if (busy_s1) begin
			cur_q     <= nstate;
			changed_q <= fired;
		end
	end

	assign out_valid     = out_valid_q;
	assign current_state = cur_q;
	assign changed       = changed_q;

endmodule

// ===== hdl/cts_ram.sv =====
module cts_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/cts_checker.sv =====
module cts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         op,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         current_state,
	input logic               changed
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(current_state) && $stable(changed))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	// every accepted item raises out_valid once the compare step has loaded the result register
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing after transfer");

	// load items never report a transition
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == cts_pkg::OpLoad) |=> ##1 !changed)
		else $error("load item reported a change");

endmodule

bind condition_table_state_machine cts_checker u_cts_checker (.*);
